/* rtl/dep_pkg.sv */
// Package for the double-ended priority queue.
// Holds the capacity, the word types, the operation codes and the chain control struct.
// Used by dep_cell, dep_chain and double_ended_priority_queue.
`timescale 1ns / 1ps

package dep_pkg;

    localparam int Capacity = 256;
    localparam int CountW   = $clog2(Capacity + 1);
    localparam int ValueW   = 32;
    localparam int KindW    = 2;
    localparam int OutCntW  = 9;

    typedef logic signed [ValueW-1:0] t_value;
    typedef logic [CountW-1:0]        t_count;

    typedef enum logic [KindW-1:0] {
        KIND_INSERT   = 2'd0,
        KIND_TAKE_MAX = 2'd1,
        KIND_TAKE_MIN = 2'd2,
        KIND_NOP      = 2'd3
    } t_kind;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_chain_op;

endpackage

/* rtl/dep_cell.sv */
// One cell of the sorted chain: holds one word and moves it to stay in order.
// Depends on dep_pkg.
`timescale 1ns / 1ps

module dep_cell (
    input  logic              i_clk,
    input  dep_pkg::t_chain_op i_op,
    input  dep_pkg::t_value   i_value,
    input  logic              i_occupied,
    input  dep_pkg::t_value   i_left_data,
    input  logic              i_left_gt,
    input  dep_pkg::t_value   i_right_data,
    output dep_pkg::t_value   o_data,
    output logic              o_gt
);

    dep_pkg::t_value r_data;
    dep_pkg::t_value n_data;

    assign o_gt   = !i_occupied || (r_data > i_value);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_op.insert && o_gt) begin
            n_data = i_left_gt ? i_left_data : i_value;
        end else if (i_op.shift) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* rtl/dep_chain.sv */
// A row of dep_cell instances that keeps its occupied words in ascending order.
// An insert opens a gap at the insertion point; a shift drops the head word.
// Depends on dep_pkg and dep_cell.
`timescale 1ns / 1ps

module dep_chain (
    input  logic               i_clk,
    input  dep_pkg::t_chain_op i_op,
    input  dep_pkg::t_value    i_value,
    input  dep_pkg::t_count    i_count,
    output dep_pkg::t_value    o_head
);

    dep_pkg::t_value w_data [dep_pkg::Capacity];
    logic            w_gt   [dep_pkg::Capacity];

    for (genvar gi = 0; gi < dep_pkg::Capacity; gi++) begin : g_cell
        dep_pkg::t_value w_left_data;
        dep_pkg::t_value w_right_data;
        logic            w_left_gt;
        logic            w_occupied;

        assign w_occupied = dep_pkg::CountW'(gi) < i_count;

        if (gi == 0) begin : g_first
            assign w_left_data = '0;
            assign w_left_gt   = 1'b0;
        end else begin : g_inner
            assign w_left_data = w_data[gi-1];
            assign w_left_gt   = w_gt[gi-1];
        end

        if (gi == dep_pkg::Capacity - 1) begin : g_last
            assign w_right_data = w_data[gi];
        end else begin : g_mid
            assign w_right_data = w_data[gi+1];
        end

        dep_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (i_op),
            .i_value      (i_value),
            .i_occupied   (w_occupied),
            .i_left_data  (w_left_data),
            .i_left_gt    (w_left_gt),
            .i_right_data (w_right_data),
            .o_data       (w_data[gi]),
            .o_gt         (w_gt[gi])
        );
    end

    assign o_head = w_data[0];

endmodule

/* rtl/double_ended_priority_queue.sv */
// Double-ended priority queue over signed 32-bit words: top level.
// Holds an ascending chain for the minimum and an inverted chain for the maximum.
// Depends on dep_pkg and dep_chain.
//
// Usage:
// The input channel (i_valid, o_ready, i_kind, i_value) takes one operation word:
// insert a value, remove one copy of the largest value, or remove one copy of the
// smallest value. Code 3 is a no-op. The output channel (o_valid, i_ready) returns
// one result word per operation: the largest and smallest values (zero when empty),
// the count, an empty flag and a dropped flag for a removal from an empty store or
// an insert into a full store.
// Both chains update every cell in parallel in the cycle the operation is accepted;
// the result register then loads once it is free (o_valid low or i_ready high), and
// o_valid rises as it loads. The block works on one operation at a time, gated by
// the result register: o_ready stays low until the previous result has been loaded.
// When the receiver stalls, the finished result waits in the output register and
// one further operation may be accepted and held until that register frees up.
// Reset clears the count and all handshake state; cell contents need no clearing.
`timescale 1ns / 1ps

module double_ended_priority_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dep_pkg::KindW-1:0]   i_kind,
    input  logic signed [31:0]          i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [31:0]          o_max_value,
    output logic signed [31:0]          o_min_value,
    output logic [dep_pkg::OutCntW-1:0] o_entry_count,
    output logic                        o_is_empty,
    output logic                        o_dropped
);

    logic               r_busy;
    logic               r_drop_pend;
    dep_pkg::t_count    r_count;
    dep_pkg::t_count    n_count;
    logic               w_accept;
    logic               w_load;
    logic               w_full;
    logic               w_empty;
    logic               w_ins;
    logic               w_tmax;
    logic               w_tmin;
    logic               w_drop;
    dep_pkg::t_kind     w_kind;
    dep_pkg::t_chain_op w_asc_op;
    dep_pkg::t_chain_op w_desc_op;
    dep_pkg::t_value    w_asc_head;
    dep_pkg::t_value    w_desc_head;

    assign w_kind   = dep_pkg::t_kind'(i_kind);
    assign o_ready  = !r_busy;
    assign w_accept = i_valid && o_ready;
    assign w_load   = r_busy && (!o_valid || i_ready);

    assign w_full  = r_count == dep_pkg::CountW'(dep_pkg::Capacity);
    assign w_empty = r_count == '0;

    always_comb begin
        w_ins  = 1'b0;
        w_tmax = 1'b0;
        w_tmin = 1'b0;
        w_drop = 1'b0;
        unique case (w_kind)
            dep_pkg::KIND_INSERT: begin
                w_ins  = !w_full;
                w_drop = w_full;
            end
            dep_pkg::KIND_TAKE_MAX: begin
                w_tmax = !w_empty;
                w_drop = w_empty;
            end
            dep_pkg::KIND_TAKE_MIN: begin
                w_tmin = !w_empty;
                w_drop = w_empty;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + dep_pkg::CountW'(1);
        end else if (w_tmax || w_tmin) begin
            n_count = r_count - dep_pkg::CountW'(1);
        end
    end

    assign w_asc_op.insert  = w_accept && w_ins;
    assign w_asc_op.shift   = w_accept && w_tmin;
    assign w_desc_op.insert = w_accept && w_ins;
    assign w_desc_op.shift  = w_accept && w_tmax;

    dep_chain u_asc (
        .i_clk   (i_clk),
        .i_op    (w_asc_op),
        .i_value (i_value),
        .i_count (r_count),
        .o_head  (w_asc_head)
    );

    dep_chain u_desc (
        .i_clk   (i_clk),
        .i_op    (w_desc_op),
        .i_value (~i_value),
        .i_count (r_count),
        .o_head  (w_desc_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy  <= 1'b1;
                r_count <= n_count;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_drop_pend <= w_drop;
        end
        if (w_load) begin
            o_max_value   <= w_empty ? '0 : ~w_desc_head;
            o_min_value   <= w_empty ? '0 : w_asc_head;
            o_entry_count <= dep_pkg::OutCntW'(r_count);
            o_is_empty    <= w_empty;
            o_dropped     <= r_drop_pend;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dep_pkg::CountW'(dep_pkg::Capacity))
        else $error("stored count exceeds capacity");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("count changed without an accepted word");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_empty |-> o_min_value <= o_max_value)
        else $error("reported minimum exceeds reported maximum");

    a_load_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("accepted word not held for the result register");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the double-ended priority queue.
// It keeps a sorted shadow store, predicts every result word and checks each one in order.
// Depends on dep_pkg and double_ended_priority_queue.
`timescale 1ns / 1ps

module tb_top;

    localparam int CycleLimit  = 500000;
    localparam int RandomWords = 2000;

    typedef struct {
        dep_pkg::t_kind  kind;
        dep_pkg::t_value value;
        bit              drain_first;
    } t_op_word;

    typedef struct {
        dep_pkg::t_value             max_v;
        dep_pkg::t_value             min_v;
        logic [dep_pkg::OutCntW-1:0] count;
        logic                        empty;
        logic                        dropped;
    } t_summary;

    logic                        i_clk;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [dep_pkg::KindW-1:0]   i_kind  = '0;
    logic signed [31:0]          i_value = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic signed [31:0]          o_max_value;
    logic signed [31:0]          o_min_value;
    logic [dep_pkg::OutCntW-1:0] o_entry_count;
    logic                        o_is_empty;
    logic                        o_dropped;

    t_op_word        ops_to_send[$];
    t_summary        summary_due[$];
    dep_pkg::t_value shadow_sorted[$];

    int  total_ops     = 1;
    int  ops_accepted  = 0;
    int  errors        = 0;
    int  cycle_count   = 0;
    int  hold_left     = 0;
    int  holds_done    = 0;
    int  run_phase;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    bit  in_taken      = 1'b0;

    double_ended_priority_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_max_value   (o_max_value),
        .o_min_value   (o_min_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_dropped     (o_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_summary apply_operation(dep_pkg::t_kind kind,
                                                 dep_pkg::t_value value);
        t_summary s;
        int       pos;
        s.dropped = 1'b0;
        case (kind)
            dep_pkg::KIND_INSERT: begin
                if (shadow_sorted.size() >= dep_pkg::Capacity) begin
                    s.dropped = 1'b1;
                end else begin
                    pos = shadow_sorted.size();
                    while (pos > 0 && shadow_sorted[pos-1] > value) pos--;
                    shadow_sorted.insert(pos, value);
                end
            end
            dep_pkg::KIND_TAKE_MAX: begin
                if (shadow_sorted.size() == 0) s.dropped = 1'b1;
                else void'(shadow_sorted.pop_back());
            end
            dep_pkg::KIND_TAKE_MIN: begin
                if (shadow_sorted.size() == 0) s.dropped = 1'b1;
                else void'(shadow_sorted.pop_front());
            end
            default: begin
            end
        endcase
        s.count = dep_pkg::OutCntW'(shadow_sorted.size());
        s.empty = (shadow_sorted.size() == 0);
        if (s.empty) begin
            s.max_v = '0;
            s.min_v = '0;
        end else begin
            s.max_v = shadow_sorted[shadow_sorted.size()-1];
            s.min_v = shadow_sorted[0];
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic add_op(input dep_pkg::t_kind kind, input dep_pkg::t_value value,
                          input bit drain_first);
        t_op_word w;
        w.kind        = kind;
        w.value       = value;
        w.drain_first = drain_first;
        ops_to_send.push_back(w);
    endtask

    function automatic dep_pkg::t_value pick_value();
        int tmp;
        case ($urandom_range(0, 3))
            0: return dep_pkg::t_value'($urandom);
            1: begin
                tmp = $urandom_range(0, 16);
                return dep_pkg::t_value'(tmp - 8);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return dep_pkg::t_value'($signed($urandom) >>> 12);
        endcase
    endfunction

    always_comb begin
        run_phase = (ops_accepted * 3) / total_ops;
        case (run_phase)
            0: begin
                sender_idle_pct   = 10;
                receiver_idle_pct = 60;
            end
            1: begin
                sender_idle_pct   = 60;
                receiver_idle_pct = 10;
            end
            default: begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
        endcase
    end

    always @(negedge i_clk) begin : driver
        t_op_word next_word;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (ops_to_send.size() > 0 &&
                !(ops_to_send[0].drain_first && summary_due.size() > 0) &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
                next_word = ops_to_send.pop_front();
                i_valid <= 1'b1;
                i_kind  <= next_word.kind;
                i_value <= next_word.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls for long stretches twice, the second time while the sender never idles.
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && ops_accepted >= 40) ||
                     (holds_done == 1 && ops_accepted >= (total_ops * 5) / 6)) begin
            i_ready    <= 1'b0;
            hold_left  <= 300;
            holds_done <= holds_done + 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_summary want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                if (summary_due.size() == 0) begin
                    report_mismatch("unexpected result word", '0, '0);
                end else begin
                    want = summary_due.pop_front();
                    if (o_max_value !== want.max_v)
                        report_mismatch("max_value", o_max_value, want.max_v);
                    if (o_min_value !== want.min_v)
                        report_mismatch("min_value", o_min_value, want.min_v);
                    if (o_entry_count !== want.count)
                        report_mismatch("entry_count", 32'(o_entry_count), 32'(want.count));
                    if (o_is_empty !== want.empty)
                        report_mismatch("is_empty", 32'(o_is_empty), 32'(want.empty));
                    if (o_dropped !== want.dropped)
                        report_mismatch("dropped", 32'(o_dropped), 32'(want.dropped));
                end
            end
            if (i_valid && o_ready) begin
                summary_due.push_back(apply_operation(dep_pkg::t_kind'(i_kind), i_value));
                ops_accepted <= ops_accepted + 1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int directed_ops;
        int seg;
        int seg_len;
        int insert_pct;
        int r;
        int k;

        add_op(dep_pkg::KIND_TAKE_MAX, '0, 1'b0);
        add_op(dep_pkg::KIND_TAKE_MIN, '1, 1'b0);
        add_op(dep_pkg::KIND_NOP, 32'sh7fff_ffff, 1'b0);
        add_op(dep_pkg::KIND_INSERT, '0, 1'b0);
        add_op(dep_pkg::KIND_INSERT, 32'sh8000_0000, 1'b0);
        add_op(dep_pkg::KIND_INSERT, 32'sh7fff_ffff, 1'b0);
        add_op(dep_pkg::KIND_INSERT, '1, 1'b0);
        add_op(dep_pkg::KIND_INSERT, 32'sd1, 1'b0);
        add_op(dep_pkg::KIND_INSERT, 32'sh7fff_ffff, 1'b0);
        add_op(dep_pkg::KIND_INSERT, 32'sh8000_0000, 1'b0);
        add_op(dep_pkg::KIND_INSERT, 32'sd5, 1'b0);
        add_op(dep_pkg::KIND_INSERT, 32'sd5, 1'b0);
        add_op(dep_pkg::KIND_NOP, '1, 1'b0);
        for (k = 0; k < 9; k++) begin
            add_op((k % 2 == 0) ? dep_pkg::KIND_TAKE_MAX : dep_pkg::KIND_TAKE_MIN,
                   pick_value(), 1'b0);
        end
        add_op(dep_pkg::KIND_TAKE_MIN, '0, 1'b0);
        directed_ops = ops_to_send.size();

        // Mixed segments alternate their insert bias so the fill level wanders;
        // one segment fills the store past capacity and then drains it past empty.
        seg = 0;
        while (ops_to_send.size() < directed_ops + RandomWords) begin
            if (seg == 3) begin
                for (k = 0; k < dep_pkg::Capacity + 6; k++) begin
                    add_op(dep_pkg::KIND_INSERT, pick_value(), k == 0);
                end
                for (k = 0; k < dep_pkg::Capacity + 14; k++) begin
                    add_op($urandom_range(0, 1) ? dep_pkg::KIND_TAKE_MAX
                                                : dep_pkg::KIND_TAKE_MIN,
                           pick_value(), 1'b0);
                end
            end else begin
                seg_len    = $urandom_range(20, 60);
                insert_pct = (seg % 3 == 0) ? 50 : ((seg % 3 == 1) ? 75 : 25);
                for (k = 0; k < seg_len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < insert_pct)
                        add_op(dep_pkg::KIND_INSERT, pick_value(),
                               (k == 0) && (seg % 6 == 5));
                    else if (r < 96)
                        add_op($urandom_range(0, 1) ? dep_pkg::KIND_TAKE_MAX
                                                    : dep_pkg::KIND_TAKE_MIN,
                               pick_value(), (k == 0) && (seg % 6 == 5));
                    else
                        add_op(dep_pkg::KIND_NOP, pick_value(),
                               (k == 0) && (seg % 6 == 5));
                end
            end
            seg++;
        end
        total_ops = ops_to_send.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_to_send.size() > 0 || i_valid || summary_due.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/dep_pkg.sv
rtl/dep_cell.sv
rtl/dep_chain.sv
rtl/double_ended_priority_queue.sv
tb/sv/tb_top.sv
